>>> rtl/small_matrix_multiply_macros.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef SMALL_MATRIX_MULTIPLY_MACROS_SVH
`define SMALL_MATRIX_MULTIPLY_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SMM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smm check failed");

`define SMM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smm check failed");

`else

`define SMM_ASSERT_IMP(name, ante, cons)

`define SMM_ASSERT_NXT(name, ante, cons)

`endif

`endif

>>> rtl/smm_pkg.sv
package smm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RC_W   = 2;

  // travels with each multiply-accumulate step down the pipeline
  typedef struct packed {
    logic            first;
    logic            last_k;
    logic            last_cell;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } smm_tag_t;

  typedef struct packed {
    logic     issue;
    logic     wr_left;
    logic     wr_right;
    smm_tag_t tag;
  } smm_cmd_t;

endpackage

>>> rtl/smm_ctrl.sv
`include "small_matrix_multiply_macros.svh"

module smm_ctrl #(
  parameter int unsigned DIM = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             stall_i,
  output smm_pkg::smm_cmd_t                cmd_o,
  output logic [$clog2(DIM*DIM)-1:0]       wr_addr_o,
  output logic [$clog2(DIM*DIM)-1:0]       rd_a_addr_o,
  output logic [$clog2(DIM*DIM)-1:0]       rd_b_addr_o
);

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned KW    = $clog2(DIM);
  localparam logic [AW-1:0] LastCell = AW'(CELLS - 1);
  localparam logic [KW-1:0] LastIdx  = KW'(DIM - 1);

  localparam logic StLoad = 1'b0;
  localparam logic StRun  = 1'b1;

  logic          state_q, state_d;
  logic          phase_q, phase_d;   // 0 while taking A, 1 while taking B
  logic [AW-1:0] cell_q, cell_d;
  logic [KW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic          load_fire;
  logic          issue;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cell_d    = cell_q;
    r_d       = r_q;
    c_d       = c_q;
    k_d       = k_q;
    load_fire = in_valid_i && (state_q == StLoad);
    issue     = (state_q == StRun) && !stall_i;
    unique case (state_q)
      StLoad: begin
        if (load_fire) begin
          if (cell_q == LastCell) begin
            cell_d  = '0;
            phase_d = !phase_q;
            if (phase_q) begin
              state_d = StRun;
            end
          end else begin
            cell_d = cell_q + AW'(1);
          end
        end
      end
      StRun: begin
        if (issue) begin
          if (k_q == LastIdx) begin
            k_d = '0;
            if (c_q == LastIdx) begin
              c_d = '0;
              if (r_q == LastIdx) begin
                r_d     = '0;
                state_d = StLoad;
              end else begin
                r_d = r_q + KW'(1);
              end
            end else begin
              c_d = c_q + KW'(1);
            end
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      phase_q <= 1'b0;
      cell_q  <= '0;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cell_q  <= cell_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  assign in_ready_o = (state_q == StLoad);
  assign wr_addr_o  = cell_q;

  assign rd_a_addr_o = AW'(DIM * 32'(r_q) + 32'(k_q));
  assign rd_b_addr_o = AW'(DIM * 32'(k_q) + 32'(c_q));

  always_comb begin
    cmd_o.issue         = issue;
    cmd_o.wr_left       = load_fire && !phase_q;
    cmd_o.wr_right      = load_fire && phase_q;
    cmd_o.tag.first     = (k_q == '0);
    cmd_o.tag.last_k    = (k_q == LastIdx);
    cmd_o.tag.last_cell = (r_q == LastIdx) && (c_q == LastIdx) && (k_q == LastIdx);
    cmd_o.tag.row       = smm_pkg::RC_W'(r_q);
    cmd_o.tag.col       = smm_pkg::RC_W'(c_q);
  end

  `SMM_ASSERT_IMP(a_no_load_while_run, cmd_o.issue, !in_ready_o)
  `SMM_ASSERT_NXT(a_run_after_b, load_fire && phase_q && (cell_q == LastCell), state_q == StRun)
  `SMM_ASSERT_IMP(a_one_store_written, load_fire, cmd_o.wr_left != cmd_o.wr_right)

endmodule

>>> rtl/smm_datapath.sv
`include "small_matrix_multiply_macros.svh"

module smm_datapath #(
  parameter int unsigned DIM = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  smm_pkg::smm_cmd_t                  cmd_i,
  input  logic [$clog2(DIM*DIM)-1:0]         wr_addr_i,
  input  logic [$clog2(DIM*DIM)-1:0]         rd_a_addr_i,
  input  logic [$clog2(DIM*DIM)-1:0]         rd_b_addr_i,
  input  logic [smm_pkg::DATA_W-1:0]         wr_data_i,
  output logic                               stall_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [smm_pkg::DATA_W-1:0]         out_data_o,
  output logic [smm_pkg::RC_W-1:0]           out_row_o,
  output logic [smm_pkg::RC_W-1:0]           out_col_o,
  output logic                               out_last_o
);

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned DW    = smm_pkg::DATA_W;

  logic [DW-1:0] left_mem  [CELLS];
  logic [DW-1:0] right_mem [CELLS];

  logic              stall;
  logic [DW-1:0]     a_q, b_q;
  logic              s1_v_q, s2_v_q;
  smm_pkg::smm_tag_t s1_tag_q, s2_tag_q;
  logic [DW-1:0]     prod_q;
  logic [DW-1:0]     acc_q;
  logic [DW-1:0]     sum;
  logic              done;
  logic              out_valid_q, out_valid_d;
  logic [DW-1:0]     out_data_q;
  logic [smm_pkg::RC_W-1:0] out_row_q, out_col_q;
  logic              out_last_q;

  // whole pipeline holds while a finished element waits at the output
  assign stall   = out_valid_q && !out_ready_i;
  assign stall_o = stall;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_left) begin
      left_mem[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.issue) begin
      a_q <= left_mem[rd_a_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_right) begin
      right_mem[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.issue) begin
      b_q <= right_mem[rd_b_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (!stall) begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  // low word of the product is the same for signed and unsigned operands
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_tag_q <= cmd_i.tag;
      s2_tag_q <= s1_tag_q;
      prod_q   <= DW'(a_q * b_q);
    end
  end

  assign sum  = s2_tag_q.first ? prod_q : acc_q + prod_q;
  assign done = !stall && s2_v_q && s2_tag_q.last_k;

  always_ff @(posedge clk_i) begin
    if (!stall && s2_v_q) begin
      acc_q <= sum;
    end
    if (done) begin
      out_data_q <= sum;
      out_row_q  <= s2_tag_q.row;
      out_col_q  <= s2_tag_q.col;
      out_last_q <= s2_tag_q.last_cell;
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

  `SMM_ASSERT_NXT(a_done_shows, done, out_valid_q)
  `SMM_ASSERT_IMP(a_last_cell_ends_dot, s2_v_q && s2_tag_q.last_cell, s2_tag_q.last_k)
  `SMM_ASSERT_NXT(a_stall_freezes, stall, $stable(s2_v_q) && $stable(s1_v_q))

endmodule

>>> rtl/small_matrix_multiply.sv
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------
// in       | in_valid_i / in_ready_o    | element_i (A row-major, then B)
// out      | out_valid_o / out_ready_i  | product_element_o, row_o, col_o, last_o
//
// loading accepts one element per cycle, 2*DIM*DIM elements per matrix pair
// the product then runs DIM*DIM*DIM steps on one shared multiply-accumulate,
// one step a cycle unless the output stalls; with DIM=4, 64 steps for 32 input beats
// each result passes the operand, product and output registers; one beat per DIM steps
// input is refused while the product runs; a held output beat freezes the pipeline
// reset clears all control state; the matrix stores start undefined
module small_matrix_multiply #(
  parameter int unsigned DIM = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] product_element_o,
  output logic [1:0]         row_o,
  output logic [1:0]         col_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(DIM * DIM);

  smm_pkg::smm_cmd_t            cmd;
  logic                         stall;
  logic [AW-1:0]                wr_addr, rd_a_addr, rd_b_addr;
  logic [smm_pkg::DATA_W-1:0]   out_data;

  smm_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .stall_i     (stall),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_a_addr_o (rd_a_addr),
    .rd_b_addr_o (rd_b_addr)
  );

  smm_datapath #(
    .DIM (DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .wr_addr_i   (wr_addr),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .wr_data_i   (element_i),
    .stall_o     (stall),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .out_row_o   (row_o),
    .out_col_o   (col_o),
    .out_last_o  (last_o)
  );

  assign product_element_o = out_data;

endmodule

>>> tb/small_matrix_multiply_tb.sv
`timescale 1ns / 100ps

module small_matrix_multiply_tb;

  localparam int unsigned DIM        = 4;
  localparam int unsigned CELLS      = DIM * DIM;
  localparam int unsigned PAIR_LEN   = 2 * CELLS;
  localparam int unsigned RAND_PAIRS = 14;
  localparam int unsigned IDLE_PCT   = 19;
  localparam int unsigned DRAIN_CYC  = 120;
  localparam int unsigned CYCLE_CAP  = 200000;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        last;
  } product_beat_t;

  class matrix_product_board;
    logic [31:0]   left_cells[CELLS];
    logic [31:0]   right_cells[CELLS];
    int unsigned   loaded;
    product_beat_t awaited[$];
    int unsigned   errors;
    int unsigned   elements_in;
    int unsigned   beats_checked;
    int unsigned   pairs_done;

    function new();
      loaded        = 0;
      errors        = 0;
      elements_in   = 0;
      beats_checked = 0;
      pairs_done    = 0;
    endfunction

    // one row of A against one column of B, wrapping at 32 bits
    function logic [31:0] dot_cell(int unsigned r, int unsigned c);
      logic [31:0] acc;
      acc = '0;
      for (int unsigned k = 0; k < DIM; k++) begin
        acc = acc + left_cells[r*DIM + k] * right_cells[k*DIM + c];
      end
      return acc;
    endfunction

    function void note_element(logic [31:0] v);
      product_beat_t b;
      elements_in++;
      if (loaded < CELLS) left_cells[loaded] = v;
      else right_cells[loaded - CELLS] = v;
      loaded++;
      if (loaded == PAIR_LEN) begin
        loaded = 0;
        pairs_done++;
        for (int unsigned r = 0; r < DIM; r++) begin
          for (int unsigned c = 0; c < DIM; c++) begin
            b.value = dot_cell(r, c);
            b.row   = r[1:0];
            b.col   = c[1:0];
            b.last  = (r == DIM - 1) && (c == DIM - 1);
            awaited.push_back(b);
          end
        end
      end
    endfunction

    function void check_beat(logic [31:0] value, logic [1:0] row, logic [1:0] col,
                             logic last);
      product_beat_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected product beat value %h row %0d col %0d last %0b",
                 $time, value, row, col, last);
        errors++;
        return;
      end
      e = awaited.pop_front();
      beats_checked++;
      if (value !== e.value) begin
        $display("%0t: product value expected %h actual %h", $time, e.value, value);
        errors++;
      end
      if (row !== e.row) begin
        $display("%0t: row expected %0d actual %0d", $time, e.row, row);
        errors++;
      end
      if (col !== e.col) begin
        $display("%0t: col expected %0d actual %0d", $time, e.col, col);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] element_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] product_element_o;
  logic [1:0]         row_o;
  logic [1:0]         col_o;
  logic               last_o;

  matrix_product_board products = new();
  bit                  steady;
  int unsigned         cycles;

  small_matrix_multiply #(.DIM(DIM)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .element_i        (element_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .product_element_o(product_element_o),
    .row_o            (row_o),
    .col_o            (col_o),
    .last_o           (last_o)
  );

  always #2 clk_i = ~clk_i;

  // result side: random stalls, collect and check accepted beats
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      products.check_beat(product_element_o, row_o, col_o, last_o);
    end
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d product beats still awaited",
               cycles, products.awaited.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] pick_element();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($signed($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // called at a rising edge; returns at the edge that accepted the beat
  task automatic send_element(logic [31:0] v);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    element_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    products.note_element(v);
  endtask

  // hold off the sender until the product of the last pair has fully drained
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (products.awaited.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] corner[5];
    corner      = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    element_i   = '0;
    out_ready_i = 1'b0;
    steady      = 1'b0;
    cycles      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner values in both matrices, then let the product drain
    for (int unsigned i = 0; i < PAIR_LEN; i++) begin
      send_element(corner[(i < CELLS) ? i % 5 : (i + 2) % 5]);
    end
    wait_drained();
    @(posedge clk_i);

    for (int unsigned p = 0; p < RAND_PAIRS; p++) begin
      steady = (p >= 5) && (p <= 7);
      for (int unsigned i = 0; i < PAIR_LEN; i++) begin
        send_element(pick_element());
      end
      if (p == 3 || p == 9) begin
        wait_drained();
        @(posedge clk_i);
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (products.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("ran %0d matrix pairs (%0d elements in), checked %0d product beats",
             products.pairs_done, products.elements_in, products.beats_checked);
    $display("corner values, random stalls on both sides, and drained pauses");
    if (products.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", products.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
